[rtl/assert_macros.svh]
// assertion macros shared by the rtl
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

[rtl/ivs_pkg.sv]
// package for the int8 vector similarity block
// types and constants shared by front, queue and back
package ivs_pkg;
    localparam int MAX_LENGTH = 4096;
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int QDEPTH = 2;
    localparam logic [15:0] COS_NEG_ONE = 16'h8000;
    localparam logic [15:0] COS_SAT = 16'h7FFF;

    typedef struct packed {
        logic       last_element;
        logic [7:0] elem_b;
        logic [7:0] elem_a;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cosine_q15;
        logic [30:0] sq_distance;
        logic [30:0] dot_sum;
    } out_item_t;

    // finished sums handed from front to back
    typedef struct packed {
        logic [31:0] dot;
        logic [31:0] dsq;
        logic [31:0] na;
        logic [31:0] nb;
    } sums_t;
endpackage

[rtl/int8_vector_similarity_top.sv]
// top level of the int8 vector similarity block
// depends on ivs_pkg, ivs_front, ivs_queue, ivs_back, assert_macros.svh
// One element pair is taken per cycle while the queue has room, and folded
// into four sums. On the last pair the sums are queued and a back end computes
// the cosine by a 15-bit search, each bit stepping through the S_CC, S_M1,
// S_M2 and S_CMP states with 32-bit wide multiplies. Two finished vectors may
// wait in the queue; short vectors outpacing the back end stall the input.
`include "assert_macros.svh"
module int8_vector_similarity_top import ivs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    sums_t fq_data, qb_data;

    ivs_front u_front (.aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));
    ivs_queue u_queue (.aclk, .aresetn, .wr_valid(fq_valid), .wr_ready(fq_ready),
        .wr_data(fq_data), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data));
    ivs_back u_back (.aclk, .aresetn, .q_valid(qb_valid), .q_ready(qb_ready),
        .q_data(qb_data), .m_valid, .m_ready, .m_data);

    `ASSERT_IMPL(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `ASSERT_NEVER(a_no_drop, aclk, aresetn, fq_valid && !fq_ready)
    `ASSERT_IMPL(a_zero_cos, aclk, aresetn, qb_valid && qb_ready && (qb_data.na == '0) |=> ##2 m_valid && m_data.cosine_q15 == COS_NEG_ONE)
endmodule

[rtl/ivs_front.sv]
// front: accumulates the four sums, one element pair per cycle while the queue has room
// depends on ivs_pkg
module ivs_front import ivs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output sums_t    q_data
);
    logic [31:0] dot_reg, dist_reg, na_reg, nb_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [8:0] a, b, d;
    logic signed [17:0] pab;
    logic [17:0] pdd;
    logic [15:0] paa, pbb;
    logic take, acc_en;
    sums_t nxt;

    assign s_ready = q_ready;
    assign take = s_valid & s_ready;
    assign a = {s_data.elem_a[7], s_data.elem_a};
    assign b = {s_data.elem_b[7], s_data.elem_b};
    assign d = a - b;
    assign pab = a * b;
    assign pdd = 18'(d * d);
    assign paa = 16'(a * a);
    assign pbb = 16'(b * b);
    assign acc_en = cnt_reg < CNT_W'(MAX_LENGTH);

    always_comb begin
        nxt.dot = dot_reg;
        nxt.dsq = dist_reg;
        nxt.na = na_reg;
        nxt.nb = nb_reg;
        if (acc_en) begin
            nxt.dot = dot_reg + 32'(pab);
            nxt.dsq = dist_reg + {14'd0, pdd};
            nxt.na = na_reg + {16'd0, paa};
            nxt.nb = nb_reg + {16'd0, pbb};
        end
    end

    assign q_valid = take & s_data.last_element;
    assign q_data = nxt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            dist_reg <= '0;
            na_reg <= '0;
            nb_reg <= '0;
            cnt_reg <= '0;
        end else if (take) begin
            if (s_data.last_element) begin
                dot_reg <= '0;
                dist_reg <= '0;
                na_reg <= '0;
                nb_reg <= '0;
                cnt_reg <= '0;
            end else begin
                dot_reg <= nxt.dot;
                dist_reg <= nxt.dsq;
                na_reg <= nxt.na;
                nb_reg <= nxt.nb;
                if (acc_en) cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end
endmodule

[rtl/ivs_queue.sv]
// small fifo of finished sums between front and back
// depends on ivs_pkg
module ivs_queue import ivs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  sums_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output sums_t rd_data
);
    localparam int AW = $clog2(QDEPTH);
    sums_t mem [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem[rp_reg];
    assign wr = wr_valid & wr_ready;
    assign rd = rd_valid & rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

[rtl/ivs_back.sv]
// back: cosine by bit-serial square-root search, each bit taking the S_CC, S_M1, S_M2 and S_CMP states
// depends on ivs_pkg
module ivs_back import ivs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  sums_t     q_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_P = 3'd2, S_CC = 3'd3,
                           S_M1 = 3'd4, S_M2 = 3'd5, S_CMP = 3'd6, S_OUT = 3'd7;
    logic [2:0] st_reg;
    logic [30:0] dot_reg, dist_reg;
    logic [31:0] mag_reg, na_reg, nb_reg;
    logic neg_reg, zero_reg;
    logic [63:0] q_reg, p_reg;
    logic [29:0] cc_reg;
    logic [93:0] t_reg;
    logic [14:0] m_reg, c;
    logic [3:0] bit_reg;
    logic [15:0] cos;
    logic [93:0] qs;

    assign c = m_reg | (15'd1 << bit_reg);
    assign qs = {q_reg, 30'd0};
    assign q_ready = st_reg == S_IDLE;
    assign m_valid = st_reg == S_OUT;
    assign cos = zero_reg ? COS_NEG_ONE : (neg_reg ? 16'(-{1'b0, m_reg}) : {1'b0, m_reg});
    assign m_data = '{cosine_q15: cos, sq_distance: dist_reg, dot_sum: dot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            unique case (st_reg)
                S_IDLE: if (q_valid) begin
                    dot_reg <= q_data.dot[30:0];
                    dist_reg <= q_data.dsq[30:0];
                    neg_reg <= q_data.dot[31];
                    mag_reg <= q_data.dot[31] ? -q_data.dot : q_data.dot;
                    na_reg <= q_data.na;
                    nb_reg <= q_data.nb;
                    zero_reg <= (q_data.na == '0) | (q_data.nb == '0);
                    m_reg <= '0;
                    bit_reg <= 4'd14;
                    st_reg <= S_SQ;
                end
                S_SQ: begin
                    q_reg <= 64'(mag_reg) * 64'(mag_reg);
                    st_reg <= S_P;
                end
                S_P: begin
                    p_reg <= 64'(na_reg) * 64'(nb_reg);
                    st_reg <= zero_reg ? S_OUT : S_CC;
                end
                S_CC: begin
                    cc_reg <= 30'(c) * 30'(c);
                    st_reg <= S_M1;
                end
                S_M1: begin
                    t_reg <= 94'(cc_reg) * 94'(p_reg[31:0]);
                    st_reg <= S_M2;
                end
                S_M2: begin
                    t_reg <= t_reg + ((94'(cc_reg) * 94'(p_reg[63:32])) << 32);
                    st_reg <= S_CMP;
                end
                S_CMP: begin
                    if (t_reg <= qs) m_reg <= c;
                    if (bit_reg == 4'd0) begin
                        st_reg <= S_OUT;
                    end else begin
                        bit_reg <= bit_reg - 1'b1;
                        st_reg <= S_CC;
                    end
                end
                S_OUT: if (m_ready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
